[hw/rtl/clipped_blit_key_blend_unit_defines.svh]
// Assertion macros for the clipped blit / color key / blend unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CLIPPED_BLIT_KEY_BLEND_UNIT_DEFINES_SVH
`define CLIPPED_BLIT_KEY_BLEND_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define CBKB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbkb check failed");
// next-cycle implication, disabled during reset
`define CBKB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbkb check failed");
`else
`define CBKB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBKB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/cbkb_pkg.sv]
// Shared types, constants and helpers for the clipped blit / key / blend unit.
// No dependencies.
package cbkb_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;
    localparam int CFG_DIM_W       = 11;  // width of dimension and offset registers
    localparam int COORD_W         = 10;  // source column / row width
    localparam int PIX_W           = 32;
    localparam int CHAN_W          = 8;
    localparam int ADDR_W          = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_KEY   = 2'd1,
        MODE_BLEND = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_WIDTH   = 3'd0,
        REG_DEST_HEIGHT  = 3'd1,
        REG_X_OFFSET     = 3'd2,
        REG_Y_OFFSET     = 3'd3,
        REG_BLIT_MODE    = 3'd4,
        REG_KEY_COLOR    = 3'd5,
        REG_BLEND_FACTOR = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0] dest_width;
        logic [CFG_DIM_W-1:0] dest_height;
        logic [CFG_DIM_W-1:0] x_offset;   // two's complement
        logic [CFG_DIM_W-1:0] y_offset;   // two's complement
        logic [1:0]           blit_mode;
        logic [PIX_W-1:0]     key_color;
        logic [CHAN_W-1:0]    blend_factor;
    } cfg_t;

    // (s*f + d*(256-f)) >> 8, never above 255
    function automatic logic [CHAN_W-1:0] mix_channel(
        input logic [CHAN_W-1:0] s,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] f
    );
        logic [CHAN_W:0]     inv;
        logic [2*CHAN_W-1:0] sf;
        logic [2*CHAN_W:0]   di;
        logic [2*CHAN_W:0]   sum;
        inv = 9'd256 - {1'b0, f};
        sf  = s * f;
        di  = d * inv;
        sum = {1'b0, sf} + di;
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

[hw/rtl/cbkb_cfg_regs.sv]
// Configuration register file for the blit unit.
// Depends on cbkb_pkg (cfg_t, reg_idx_t, widths).
module cbkb_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [cbkb_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cbkb_pkg::CFG_DATA_W-1:0]   wr_data,
    output cbkb_pkg::cfg_t                    cfg
);

    cbkb_pkg::cfg_t cfg_reg;
    cbkb_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                cbkb_pkg::REG_DEST_WIDTH:
                    cfg_next.dest_width = wr_data[cbkb_pkg::CFG_DIM_W-1:0];
                cbkb_pkg::REG_DEST_HEIGHT:
                    cfg_next.dest_height = wr_data[cbkb_pkg::CFG_DIM_W-1:0];
                cbkb_pkg::REG_X_OFFSET:
                    cfg_next.x_offset = wr_data[cbkb_pkg::CFG_DIM_W-1:0];
                cbkb_pkg::REG_Y_OFFSET:
                    cfg_next.y_offset = wr_data[cbkb_pkg::CFG_DIM_W-1:0];
                cbkb_pkg::REG_BLIT_MODE:
                    cfg_next.blit_mode = wr_data[1:0];
                cbkb_pkg::REG_KEY_COLOR:
                    cfg_next.key_color = wr_data[cbkb_pkg::PIX_W-1:0];
                cbkb_pkg::REG_BLEND_FACTOR:
                    cfg_next.blend_factor = wr_data[cbkb_pkg::CHAN_W-1:0];
                default:
                    cfg_next = cfg_reg;  // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width   <= cbkb_pkg::CFG_DIM_W'(1024);
            cfg_reg.dest_height  <= cbkb_pkg::CFG_DIM_W'(1024);
            cfg_reg.x_offset     <= '0;
            cfg_reg.y_offset     <= '0;
            cfg_reg.blit_mode    <= cbkb_pkg::MODE_COPY;
            cfg_reg.key_color    <= '0;
            cfg_reg.blend_factor <= 8'd255;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/cbkb_blend.sv]
// Per-channel constant-factor blend of one packed pixel word.
// Depends on cbkb_pkg (mix_channel, widths).
module cbkb_blend (
    input  logic [cbkb_pkg::PIX_W-1:0]  src_word,
    input  logic [cbkb_pkg::PIX_W-1:0]  dst_word,
    input  logic [cbkb_pkg::CHAN_W-1:0] factor,
    output logic [cbkb_pkg::PIX_W-1:0]  mixed_word
);

    logic [cbkb_pkg::CHAN_W-1:0] red;
    logic [cbkb_pkg::CHAN_W-1:0] green;
    logic [cbkb_pkg::CHAN_W-1:0] blue;

    assign red   = cbkb_pkg::mix_channel(src_word[7:0],   dst_word[7:0],   factor);
    assign green = cbkb_pkg::mix_channel(src_word[15:8],  dst_word[15:8],  factor);
    assign blue  = cbkb_pkg::mix_channel(src_word[23:16], dst_word[23:16], factor);

    // destination keeps its extra byte
    assign mixed_word = {dst_word[31:24], blue, green, red};

endmodule

[hw/rtl/clipped_blit_key_blend_unit.sv]
// Clipped blit pixel stage: offset + clip, color key, constant-factor blend.
// A word taken with start passes the input register and then the result register to done.
// Throughput: one pixel word per cycle; busy is never raised, results cannot be stalled.
// Placement, clip, key, address multiply and blend sit between input and result regs.
// Reset (async, active low) empties the pipeline and loads the register defaults.
// Depends on cbkb_pkg, cbkb_cfg_regs, cbkb_blend and the defines header.
`include "clipped_blit_key_blend_unit_defines.svh"

module clipped_blit_key_blend_unit #(
    parameter int MAX_DIM = cbkb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel command side
    input  logic                              start,
    output logic                              busy,
    input  logic [cbkb_pkg::COORD_W-1:0]      source_col,
    input  logic [cbkb_pkg::COORD_W-1:0]      source_row,
    input  logic [cbkb_pkg::PIX_W-1:0]        source_pixel,
    input  logic [cbkb_pkg::PIX_W-1:0]        dest_pixel_in,
    // result side
    output logic                              done,
    output logic                              write_enable,
    output logic [cbkb_pkg::ADDR_W-1:0]       dest_address,
    output logic [cbkb_pkg::PIX_W-1:0]        pixel_out,
    // register write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbkb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbkb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // width that holds both the register value and MAX_DIM
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIM_W > cbkb_pkg::CFG_DIM_W) ? DIM_W : cbkb_pkg::CFG_DIM_W;
    localparam int PROD_W = 2 * CMP_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);
    // signed destination coordinate: one bit more than the offset
    localparam int DC_W = cbkb_pkg::CFG_DIM_W + 1;

    cbkb_pkg::cfg_t cfg;

    // no backpressure anywhere: both sides always ready
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    cbkb_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // effective clip size, saturated to MAX_DIM
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] h_ext;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] h_eff;

    assign w_ext = CMP_W'(cfg.dest_width);
    assign h_ext = CMP_W'(cfg.dest_height);
    assign w_eff = (w_ext > MAX_DIM_C) ? MAX_DIM_C : w_ext;
    assign h_eff = (h_ext > MAX_DIM_C) ? MAX_DIM_C : h_ext;

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                         in_valid_reg;
    logic [cbkb_pkg::COORD_W-1:0] in_col_reg;
    logic [cbkb_pkg::COORD_W-1:0] in_row_reg;
    logic [cbkb_pkg::PIX_W-1:0]   in_spix_reg;
    logic [cbkb_pkg::PIX_W-1:0]   in_dpix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_col_reg  <= source_col;
            in_row_reg  <= source_row;
            in_spix_reg <= source_pixel;
            in_dpix_reg <= dest_pixel_in;
        end
    end

    // ---------------------------------------------------------------
    // Placement, clip and key decision
    // ---------------------------------------------------------------
    logic [DC_W-1:0]                dc;
    logic [DC_W-1:0]                dr;
    logic [cbkb_pkg::CFG_DIM_W-1:0] dest_col;
    logic [cbkb_pkg::CFG_DIM_W-1:0] dest_row;
    logic                           in_clip;
    logic                           keyed;
    logic                           we_next;
    logic                           blend_sel;

    // zero-extended source coordinate plus sign-extended offset; never overflows
    assign dc = {2'b00, in_col_reg} + {cfg.x_offset[cbkb_pkg::CFG_DIM_W-1], cfg.x_offset};
    assign dr = {2'b00, in_row_reg} + {cfg.y_offset[cbkb_pkg::CFG_DIM_W-1], cfg.y_offset};
    assign dest_col = dc[DC_W-2:0];
    assign dest_row = dr[DC_W-2:0];

    assign in_clip = !dc[DC_W-1] && !dr[DC_W-1]
                  && (CMP_W'(dest_col) < w_eff)
                  && (CMP_W'(dest_row) < h_eff);
    assign keyed     = (cfg.blit_mode == cbkb_pkg::MODE_KEY) && (in_spix_reg == cfg.key_color);
    assign we_next   = in_clip && !keyed;
    assign blend_sel = (cfg.blit_mode == cbkb_pkg::MODE_BLEND);

    // ---------------------------------------------------------------
    // Address (row * width + col) and pixel value
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]           addr_full;
    logic [cbkb_pkg::PIX_W-1:0]  mixed_word;
    logic [cbkb_pkg::ADDR_W-1:0] dest_address_next;
    logic [cbkb_pkg::PIX_W-1:0]  pixel_out_next;

    assign addr_full = PROD_W'(dest_row) * PROD_W'(w_eff) + PROD_W'(dest_col);

    cbkb_blend u_blend (
        .src_word   (in_spix_reg),
        .dst_word   (in_dpix_reg),
        .factor     (cfg.blend_factor),
        .mixed_word (mixed_word)
    );

    // clipped or keyed-out words report zero address and pixel
    always_comb
    begin
        dest_address_next = '0;
        pixel_out_next    = '0;
        if (we_next)
        begin
            dest_address_next = addr_full[cbkb_pkg::ADDR_W-1:0];
            pixel_out_next    = blend_sel ? mixed_word : in_spix_reg;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                        done_reg;
    logic                        write_enable_reg;
    logic [cbkb_pkg::ADDR_W-1:0] dest_address_reg;
    logic [cbkb_pkg::PIX_W-1:0]  pixel_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            write_enable_reg <= 1'b0;
        end
        else
        begin
            done_reg         <= in_valid_reg;
            write_enable_reg <= in_valid_reg && we_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            dest_address_reg <= dest_address_next;
            pixel_out_reg    <= pixel_out_next;
        end
    end

    assign done         = done_reg;
    assign write_enable = write_enable_reg;
    assign dest_address = dest_address_reg;
    assign pixel_out    = pixel_out_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // every strobe comes from a word accepted earlier, through the input and result registers
    `CBKB_ASSERT_IMP(a_done_from_start, clk, rst_n, done, $past(start && !busy, 2))
    // write enable only rides on a strobe
    `CBKB_ASSERT_IMP(a_we_with_done, clk, rst_n, write_enable, done)
    // a dropped word carries zero address and pixel
    `CBKB_ASSERT_NXT(a_drop_zero, clk, rst_n, in_valid_reg && !we_next,
                     dest_address == '0 && pixel_out == '0)

endmodule

[dv/blit_write_tracker_pkg.sv]
// Scoreboard for the clipped blit / color key / blend pixel stage.
// Keeps a copy of the register file, predicts each pixel write, and checks what comes out.
// Depends on cbkb_pkg.
package blit_write_tracker_pkg;

    import cbkb_pkg::*;

    localparam int             CLIP_MAX    = MAX_DIM_DEFAULT;
    localparam logic [1:0]     MODE_UNUSED = 2'd3;   // decodes as plain copy

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_address;
        logic [PIX_W-1:0]  pixel_out;
    } pixel_write_t;

    // two's complement offset register to a plain int
    function automatic int offset_value(logic [CFG_DIM_W-1:0] v);
        return v[CFG_DIM_W-1] ? int'(v) - (1 << CFG_DIM_W) : int'(v);
    endfunction

    function automatic int clip_extent(logic [CFG_DIM_W-1:0] v);
        return (int'(v) > CLIP_MAX) ? CLIP_MAX : int'(v);
    endfunction

    class blit_write_tracker;

        cfg_t         settings;
        pixel_write_t pending_writes[$];
        int unsigned  failures;

        function new();
            settings.dest_width   = 11'd1024;
            settings.dest_height  = 11'd1024;
            settings.x_offset     = '0;
            settings.y_offset     = '0;
            settings.blit_mode    = MODE_COPY;
            settings.key_color    = '0;
            settings.blend_factor = 8'd255;
            failures              = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_DEST_WIDTH:   settings.dest_width   = value[CFG_DIM_W-1:0];
                REG_DEST_HEIGHT:  settings.dest_height  = value[CFG_DIM_W-1:0];
                REG_X_OFFSET:     settings.x_offset     = value[CFG_DIM_W-1:0];
                REG_Y_OFFSET:     settings.y_offset     = value[CFG_DIM_W-1:0];
                REG_BLIT_MODE:    settings.blit_mode    = value[1:0];
                REG_KEY_COLOR:    settings.key_color    = value[PIX_W-1:0];
                REG_BLEND_FACTOR: settings.blend_factor = value[CHAN_W-1:0];
                default: ;
            endcase
        endfunction

        function pixel_write_t predict_write(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                             logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
            pixel_write_t w;
            int           clip_w;
            int           clip_h;
            int           dc;
            int           dr;
            int unsigned  f;
            int unsigned  sum;
            w      = '0;
            clip_w = clip_extent(settings.dest_width);
            clip_h = clip_extent(settings.dest_height);
            dc     = int'(col) + offset_value(settings.x_offset);
            dr     = int'(row) + offset_value(settings.y_offset);
            f      = settings.blend_factor;
            if (dc >= 0 && dr >= 0 && dc < clip_w && dr < clip_h) begin
                case (settings.blit_mode)
                    MODE_BLEND: begin
                        for (int k = 0; k < 3; k++) begin
                            sum = src[8*k +: 8] * f + dst[8*k +: 8] * (256 - f);
                            w.pixel_out[8*k +: 8] = sum[15:8];
                        end
                        w.pixel_out[31:24] = dst[31:24];
                        w.write_enable     = 1'b1;
                    end
                    MODE_KEY: begin
                        if (src != settings.key_color) begin
                            w.pixel_out    = src;
                            w.write_enable = 1'b1;
                        end
                    end
                    default: begin
                        w.pixel_out    = src;
                        w.write_enable = 1'b1;
                    end
                endcase
                if (w.write_enable)
                    w.dest_address = ADDR_W'(dr * clip_w + dc);
            end
            return w;
        endfunction

        function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                 logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
            pending_writes.push_back(predict_write(col, row, src, dst));
        endfunction

        function void check_write(logic we, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
            pixel_write_t exp_w;
            if (pending_writes.size() == 0) begin
                $error("unexpected result word: write_enable %0d dest_address %h pixel_out %h",
                       we, addr, pix);
                failures++;
                return;
            end
            exp_w = pending_writes.pop_front();
            if (we !== exp_w.write_enable) begin
                $error("write_enable: expected %0d, actual %0d", exp_w.write_enable, we);
                failures++;
            end
            if (addr !== exp_w.dest_address) begin
                $error("dest_address: expected %h, actual %h", exp_w.dest_address, addr);
                failures++;
            end
            if (pix !== exp_w.pixel_out) begin
                $error("pixel_out: expected %h, actual %h", exp_w.pixel_out, pix);
                failures++;
            end
        endfunction

        function int pending();
            return pending_writes.size();
        endfunction

    endclass

endpackage

[dv/testbench.sv]
// Top-level testbench for clipped_blit_key_blend_unit: directed corner pixels, then
// randomized register settings with pixel streams aimed around the clip window.
// Depends on cbkb_pkg and blit_write_tracker_pkg.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cbkb_pkg::*;
    import blit_write_tracker_pkg::*;

    // ---------------------------------------------------------------------
    // clock, reset, block ports
    // ---------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [COORD_W-1:0]    source_col;
    logic [COORD_W-1:0]    source_row;
    logic [PIX_W-1:0]      source_pixel;
    logic [PIX_W-1:0]      dest_pixel_in;
    logic                  done;
    logic                  write_enable;
    logic [ADDR_W-1:0]     dest_address;
    logic [PIX_W-1:0]      pixel_out;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blit_write_tracker tracker;
    bit                steady;   // sender never idles while set

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    clipped_blit_key_blend_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .source_col   (source_col),
        .source_row   (source_row),
        .source_pixel (source_pixel),
        .dest_pixel_in(dest_pixel_in),
        .done         (done),
        .write_enable (write_enable),
        .dest_address (dest_address),
        .pixel_out    (pixel_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ---------------------------------------------------------------------
    // result side: done marks a word for exactly one cycle, no back-pressure.
    // Sampled at the edge that closes the cycle, before the block's own
    // nonblocking updates land.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_write(write_enable, dest_address, pixel_out);
    end

    // ---------------------------------------------------------------------
    // pixel side
    // ---------------------------------------------------------------------

    // One pixel word; each cycle ahead of it is idle with a chance of 27%.
    // Start stays high across back-to-back words, so it is only lowered for a gap.
    task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                              logic [PIX_W-1:0] src, logic [PIX_W-1:0] dst);
        while (!steady && $urandom_range(99) < 27)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        source_col    <= col;
        source_row    <= row;
        source_pixel  <= src;
        dest_pixel_in <= dst;
        do @(posedge clk); while (busy);
        tracker.note_pixel(col, row, src, dst);
    endtask

    // Hold off until every predicted write has come back.
    task automatic drain();
        if (tracker.pending() != 0)
        begin
            start <= 1'b0;
            while (tracker.pending() != 0) @(posedge clk);
        end
    endtask

    // ---------------------------------------------------------------------
    // register side
    // ---------------------------------------------------------------------
    task automatic put_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_register(idx, value);
    endtask

    // Full register load, only with the pipeline empty. cfg_valid stays high
    // across the seven writes and drops once at the end.
    task automatic load_settings(logic [CFG_DIM_W-1:0] w, logic [CFG_DIM_W-1:0] h,
                                 logic [CFG_DIM_W-1:0] xo, logic [CFG_DIM_W-1:0] yo,
                                 logic [1:0] mode, logic [PIX_W-1:0] key,
                                 logic [CHAN_W-1:0] f);
        drain();
        put_register(REG_DEST_WIDTH,   CFG_DATA_W'(w));
        put_register(REG_DEST_HEIGHT,  CFG_DATA_W'(h));
        put_register(REG_X_OFFSET,     CFG_DATA_W'(xo));
        put_register(REG_Y_OFFSET,     CFG_DATA_W'(yo));
        put_register(REG_BLIT_MODE,    CFG_DATA_W'(mode));
        put_register(REG_KEY_COLOR,    key);
        put_register(REG_BLEND_FACTOR, CFG_DATA_W'(f));
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // random choices
    // ---------------------------------------------------------------------

    // dimension: zero (clips all), one, full, oversized (saturates), tiny, any
    function automatic logic [CFG_DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(19);
        case (r)
            0:       return '0;
            1:       return 11'd1;
            2:       return 11'd1024;
            3:       return CFG_DIM_W'($urandom_range(1025, 2046));
            4:       return 11'd2047;
            5, 6, 7: return CFG_DIM_W'($urandom_range(1, 16));
            default: return CFG_DIM_W'($urandom_range(1, 1024));
        endcase
    endfunction

    // offset: both extremes, small either way, anything
    function automatic logic [CFG_DIM_W-1:0] pick_offset();
        int r;
        r = $urandom_range(9);
        case (r)
            0:             return 11'h400;
            1:             return 11'h3FF;
            2, 3, 4, 5:    return CFG_DIM_W'(int'($urandom_range(64)) - 32);
            default:       return CFG_DIM_W'($urandom);
        endcase
    endfunction

    // Mostly aim the coordinate at the clip window, a few pixels either side,
    // so edges get hit; otherwise anywhere in the source.
    function automatic logic [COORD_W-1:0] aim_coord(logic [CFG_DIM_W-1:0] off,
                                                     logic [CFG_DIM_W-1:0] size);
        int target;
        int c;
        if ($urandom_range(3) != 0)
        begin
            target = int'($urandom_range(clip_extent(size) + 7)) - 4;
            c      = target - offset_value(off);
            if (c >= 0 && c < (1 << COORD_W))
                return c[COORD_W-1:0];
        end
        return COORD_W'($urandom);
    endfunction

    task automatic random_settings();
        logic [1:0]        mode;
        logic [CHAN_W-1:0] f;
        int                r;
        r = $urandom_range(9);
        mode = (r == 9) ? MODE_UNUSED : 2'(r % 3);
        r = $urandom_range(7);
        f = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : CHAN_W'($urandom);
        load_settings(pick_dim(), pick_dim(), pick_offset(), pick_offset(), mode,
                      PIX_W'($urandom), f);
    endtask

    task automatic random_pixel();
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   src;
        col = aim_coord(tracker.settings.x_offset, tracker.settings.dest_width);
        row = aim_coord(tracker.settings.y_offset, tracker.settings.dest_height);
        src = PIX_W'($urandom);
        // in key mode, hit the key often, and its near misses now and then
        if (tracker.settings.blit_mode == MODE_KEY && $urandom_range(2) != 0)
        begin
            src = tracker.settings.key_color;
            if ($urandom_range(3) == 0)
                src[$urandom_range(PIX_W - 1)] ^= 1'b1;
        end
        send_pixel(col, row, src, PIX_W'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        tracker = new();
        steady  = 1'b0;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        source_col    <= '0;
        source_row    <= '0;
        source_pixel  <= '0;
        dest_pixel_in <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_DEST_WIDTH;
        cfg_data      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: 1024x1024, no offset, copy; corners and full-range words
        send_pixel(10'd0,    10'd0,    32'h0000_0000, 32'hFFFF_FFFF);
        send_pixel(10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'h0000_0000);
        send_pixel(10'd1023, 10'd0,    32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send_pixel(10'd0,    10'd1023, 32'h8000_0001, 32'h7FFF_FFFE);

        // 100x50 window, shifted left 10 and down 5: both sides of each clip edge
        load_settings(11'd100, 11'd50, CFG_DIM_W'(-10), 11'd5, MODE_COPY, '0, 8'd255);
        send_pixel(10'd9,   10'd0,  32'h1111_1111, 32'h2222_2222);   // left of window
        send_pixel(10'd10,  10'd0,  32'h3333_3333, 32'h4444_4444);   // first column
        send_pixel(10'd109, 10'd44, 32'h5555_5555, 32'h6666_6666);   // last col, last row
        send_pixel(10'd110, 10'd0,  32'h7777_7777, 32'h8888_8888);   // right of window
        send_pixel(10'd10,  10'd45, 32'h9999_9999, 32'hAAAA_AAAA);   // below window

        // color key: exact match keyed out, one-bit miss written, match outside clip
        load_settings(11'd100, 11'd50, CFG_DIM_W'(-10), 11'd5, MODE_KEY,
                      32'h1234_5678, 8'd255);
        send_pixel(10'd20,  10'd3, 32'h1234_5678, 32'hDEAD_BEEF);
        send_pixel(10'd20,  10'd3, 32'h9234_5678, 32'hDEAD_BEEF);
        send_pixel(10'd200, 10'd3, 32'h1234_5678, 32'hDEAD_BEEF);

        // blend at factor 0, 255 and midway; extra byte comes from the destination
        load_settings(11'd1024, 11'd1024, '0, '0, MODE_BLEND, '0, 8'd0);
        send_pixel(10'd1, 10'd1, 32'hFFFF_FFFF, 32'h00AB_CDEF);
        load_settings(11'd1024, 11'd1024, '0, '0, MODE_BLEND, '0, 8'd255);
        send_pixel(10'd1, 10'd1, 32'h00FF_FFFF, 32'hFF00_0000);
        load_settings(11'd1024, 11'd1024, '0, '0, MODE_BLEND, '0, 8'd128);
        send_pixel(10'd1, 10'd1, 32'h11FF_8000, 32'hEE00_FF7F);

        // unused mode code acts as copy, even on a word equal to the key
        load_settings(11'd1024, 11'd1024, '0, '0, MODE_UNUSED, 32'hFFFF_FFFF, 8'd7);
        send_pixel(10'd0, 10'd0, 32'hFFFF_FFFF, 32'h0123_4567);

        // zero width clips everything
        load_settings('0, 11'd2047, '0, '0, MODE_COPY, '0, 8'd255);
        send_pixel(10'd0, 10'd0,    32'hCAFE_F00D, 32'h0);
        send_pixel(10'd5, 10'd1023, 32'hCAFE_F00D, 32'h0);

        // oversized dimensions saturate to the maximum; top address
        load_settings(11'd2047, 11'd1025, '0, '0, MODE_COPY, '0, 8'd255);
        send_pixel(10'd1023, 10'd1023, 32'h0F0F_F0F0, 32'h0);

        // extreme offsets
        load_settings(11'd1024, 11'd1024, 11'h3FF, '0, MODE_COPY, '0, 8'd255);
        send_pixel(10'd0, 10'd7, 32'h1357_9BDF, 32'h0);   // lands on last column
        send_pixel(10'd1, 10'd7, 32'h1357_9BDF, 32'h0);   // one past it
        load_settings(11'd1024, 11'd1024, 11'h400, 11'h400, MODE_COPY, '0, 8'd255);
        send_pixel(10'd1023, 10'd1023, 32'h2468_ACE0, 32'h0);

        // random part: fresh settings each phase, one phase without idling,
        // and every third phase stops mid-stream until the pipeline empties
        for (int p = 0; p < 12; p++)
        begin
            random_settings();
            steady = (p == 4);
            for (int i = 0; i < 119; i++)
            begin
                if (p % 3 == 1 && i == 60)
                    drain();
                random_pixel();
            end
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge clk);

        if (tracker.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog: ends a run that hangs and reports it as failed
    initial
    begin
        #1ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
